/* hdl/rrqm_pkg.sv */
`timescale 1ns / 1ps
package rrqm_pkg;

	// Register field widths
	localparam int RADIUS_W = 12;
	localparam int QP_W     = 8;
	localparam int FRAME_W  = 13;
	localparam int COORD_W  = 14;
	localparam int MB_W     = 8;
	localparam int INDEX_W  = 16;
	localparam int QP_OUT_W = 6;

	// Squared distance, grid width and quantizer limit
	localparam int D2_W     = 27;
	localparam int GRID_W   = 10;
	localparam logic [QP_W:0] QP_LIMIT = 9'd51;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_RADIUS     = 3'd0,
		REG_CENTER_QP  = 3'd1,
		REG_BACK_QP    = 3'd2,
		REG_WIDTH      = 3'd3,
		REG_HEIGHT     = 3'd4
	} reg_index_t;

	// Flags travelling beside the arithmetic
	typedef struct packed {
		logic                 in_circle;
		logic [INDEX_W-1:0]   index;
	} side_t;

endpackage

/* hdl/radial_roi_qp_map_unit.sv */
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// request   start / busy              cursor_x, cursor_y, mb_col, mb_row
// result    result_valid (strobe)     qp_value, mb_index
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One request is taken every cycle; busy stays low. Each result passes
// through the one-bit-per-stage square root (12 + FRACTION_BITS stages)
// and the eight-stage divider on its way to the output.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline always advances.
module radial_roi_qp_map_unit #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [rrqm_pkg::COORD_W-1:0] cursor_x,
	input  logic signed [rrqm_pkg::COORD_W-1:0] cursor_y,
	input  logic [rrqm_pkg::MB_W-1:0]         mb_col,
	input  logic [rrqm_pkg::MB_W-1:0]         mb_row,
	output logic                              result_valid,
	output logic [rrqm_pkg::QP_OUT_W-1:0]     qp_value,
	output logic [rrqm_pkg::INDEX_W-1:0]      mb_index,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [rrqm_pkg::FRAME_W-1:0]      cfg_data
);
	import rrqm_pkg::*;

	localparam int RW = RADIUS_W + FRACTION_BITS;
	localparam int NW = QP_W + RW;

	logic [RADIUS_W-1:0]   roi_radius_q;
	logic [QP_W-1:0]       center_qp_q;
	logic [QP_W-1:0]       background_qp_q;
	logic [FRAME_W-1:0]    frame_width_q;
	logic [FRAME_W-1:0]    frame_height_q;
	logic [2*RADIUS_W-1:0] radius_sq_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_radius_q    <= 12'd256;
			center_qp_q     <= 8'd10;
			background_qp_q <= 8'd40;
			frame_width_q   <= 13'd1920;
			frame_height_q  <= 13'd1080;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_RADIUS:    roi_radius_q    <= cfg_data[RADIUS_W-1:0];
				REG_CENTER_QP: center_qp_q     <= cfg_data[QP_W-1:0];
				REG_BACK_QP:   background_qp_q <= cfg_data[QP_W-1:0];
				REG_WIDTH:     frame_width_q   <= cfg_data;
				REG_HEIGHT:    frame_height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Register the squared radius for the circle test
	always_ff @(posedge clk) begin
		radius_sq_q <= roi_radius_q * roi_radius_q;
	end

	// Derived constants of the configuration
	logic [FRAME_W-1:0] lim_x, lim_y;
	logic [GRID_W-1:0]  grid_w;
	logic               diff_neg;
	logic [QP_W-1:0]    diff_mag;
	logic [RW-1:0]      denom;

	assign lim_x    = (frame_width_q == '0) ? '0 : frame_width_q - 1'b1;
	assign lim_y    = (frame_height_q == '0) ? '0 : frame_height_q - 1'b1;
	assign grid_w   = GRID_W'(({1'b0, frame_width_q} + 14'd15) >> 4);
	assign diff_neg = background_qp_q < center_qp_q;
	assign diff_mag = diff_neg ? center_qp_q - background_qp_q
	                           : background_qp_q - center_qp_q;
	assign denom    = RW'(roi_radius_q) << FRACTION_BITS;

	// Stage 1: clamp cursor into the frame
	logic                v_s1;
	logic [FRAME_W-1:0]  cx_s1, cy_s1;
	logic [MB_W-1:0]     col_s1, row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cursor_x[COORD_W-1]) begin
			cx_s1 <= '0;
		end else if (cursor_x[FRAME_W-1:0] > lim_x) begin
			cx_s1 <= lim_x;
		end else begin
			cx_s1 <= cursor_x[FRAME_W-1:0];
		end
		priority if (cursor_y[COORD_W-1]) begin
			cy_s1 <= '0;
		end else if (cursor_y[FRAME_W-1:0] > lim_y) begin
			cy_s1 <= lim_y;
		end else begin
			cy_s1 <= cursor_y[FRAME_W-1:0];
		end
		col_s1 <= mb_col;
		row_s1 <= mb_row;
	end

	// Stage 2: offsets to the macroblock centre, row times grid width
	logic                  v_s2;
	logic signed [14:0]    dx_s2, dy_s2;
	logic [MB_W+GRID_W-1:0] rowprod_s2;
	logic [MB_W-1:0]       col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2      <= $signed({3'b000, col_s1, 4'h8}) - $signed({2'b00, cx_s1});
		dy_s2      <= $signed({3'b000, row_s1, 4'h8}) - $signed({2'b00, cy_s1});
		rowprod_s2 <= row_s1 * grid_w;
		col_s2     <= col_s1;
	end

	// Stage 3: square the offsets, finish the raster index
	logic               v_s3;
	logic [25:0]        sqx_s3, sqy_s3;
	logic [INDEX_W-1:0] idx_s3;
	logic signed [29:0] sqx_full, sqy_full;

	assign sqx_full = dx_s2 * dx_s2;
	assign sqy_full = dy_s2 * dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s3 <= sqx_full[25:0];
		sqy_s3 <= sqy_full[25:0];
		idx_s3 <= INDEX_W'(rowprod_s2) + INDEX_W'(col_s2);
	end

	// Stage 4: sum of squares and circle test
	logic              v_s4;
	logic [D2_W-1:0]   d2_s4;
	side_t             side_s4;
	logic [D2_W-1:0]   d2_sum;

	assign d2_sum = D2_W'(sqx_s3) + D2_W'(sqy_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		d2_s4             <= d2_sum;
		side_s4.in_circle <= d2_sum < D2_W'(radius_sq_q);
		side_s4.index     <= idx_s3;
	end

	// Square root of the scaled squared distance
	logic              sq_valid;
	logic [RW-1:0]     sq_root;
	side_t             sq_side;
	logic [2*RW-1:0]   radicand;

	assign radicand = (2*RW)'(d2_s4[2*RADIUS_W-1:0]) << (2*FRACTION_BITS);

	rrqm_isqrt #(
		.RW (RW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_rad    (radicand),
		.in_side   (side_s4),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// Scale the distance by the quantizer span
	logic          v_s5;
	logic [NW-1:0] num_s5;
	side_t         side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		num_s5  <= diff_mag * sq_root;
		side_s5 <= sq_side;
	end

	// Divide by the scaled radius
	logic            dv_valid;
	logic [QP_W-1:0] dv_quot;
	side_t           dv_side;

	rrqm_div #(
		.NW (NW),
		.DW (RW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_num    (num_s5),
		.denom     (denom),
		.in_side   (side_s5),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// Apply the offset, pick background outside, limit the quantizer
	logic [QP_W:0] qp_ramp, qp_pick, qp_lim;

	assign qp_ramp = diff_neg ? {1'b0, center_qp_q} - {1'b0, dv_quot}
	                          : {1'b0, center_qp_q} + {1'b0, dv_quot};
	assign qp_pick = dv_side.in_circle ? qp_ramp : {1'b0, background_qp_q};
	assign qp_lim  = (qp_pick > QP_LIMIT) ? QP_LIMIT : qp_pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		qp_value <= qp_lim[QP_OUT_W-1:0];
		mb_index <= dv_side.index;
	end

endmodule

/* hdl/rrqm_isqrt.sv */
`timescale 1ns / 1ps
module rrqm_isqrt #(
	parameter int RW = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2*RW-1:0]       in_rad,
	input  rrqm_pkg::side_t       in_side,
	output logic                  out_valid,
	output logic [RW-1:0]         out_root,
	output rrqm_pkg::side_t       out_side
);
	import rrqm_pkg::*;

	// Stage k holds the state after k result bits
	logic                v_s    [RW+1];
	logic [2*RW-1:0]     rad_s  [RW+1];
	logic [RW-1:0]       root_s [RW+1];
	logic [RW+1:0]       rem_s  [RW+1];
	side_t               side_s [RW+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = in_rad;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [RW+1:0] shifted;
		logic [RW+1:0] trial;
		logic          take;

		// Bring down two radicand bits and try the next root bit
		assign shifted = {rem_s[k][RW-1:0], rad_s[k][2*RW-1 -: 2]};
		assign trial   = {root_s[k], 2'b01};
		assign take    = shifted >= trial;

		// Valid bit resets, payload advances freely
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			root_s[k+1] <= {root_s[k][RW-2:0], take};
			rem_s[k+1]  <= take ? shifted - trial : shifted;
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

/* hdl/rrqm_div.sv */
`timescale 1ns / 1ps
module rrqm_div #(
	parameter int NW = 28,
	parameter int DW = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [NW-1:0]         in_num,
	input  logic [DW-1:0]         denom,
	input  rrqm_pkg::side_t       in_side,
	output logic                  out_valid,
	output logic [rrqm_pkg::QP_W-1:0] out_quot,
	output rrqm_pkg::side_t       out_side
);
	import rrqm_pkg::*;

	// Stage k holds the remainder after k quotient bits
	logic              v_s    [QP_W+1];
	logic [NW-1:0]     rem_s  [QP_W+1];
	logic [QP_W-1:0]   quot_s [QP_W+1];
	side_t             side_s [QP_W+1];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_num;
	assign quot_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QP_W; k++) begin : g_step
		logic [NW-1:0] shifted_den;
		logic          take;

		// Compare against the divisor aligned to this quotient bit
		assign shifted_den = NW'(denom) << (QP_W - 1 - k);
		assign take        = rem_s[k] >= shifted_den;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem_s[k] - shifted_den : rem_s[k];
			quot_s[k+1] <= {quot_s[k][QP_W-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[QP_W];
	assign out_quot  = quot_s[QP_W];
	assign out_side  = side_s[QP_W];

endmodule
